@@ rtl/base64_variant_encoder_macros.svh @@
// Assertion macros used by the base64 variant encoder back end (b64v_back).
// No dependencies; the including module must have clk and arst_n.
`ifndef BASE64_VARIANT_ENCODER_MACROS_SVH
`define BASE64_VARIANT_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64V_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64V_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/b64v_pkg.sv @@
// Package for the base64 variant encoder: group record, constants, symbol map.
// No dependencies.
`timescale 1ns / 1ps
package b64v_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int CHARS_PER_GROUP = 4;
	localparam logic [7:0] PAD_CHAR = 8'h5F;
	localparam logic [1:0] LAST_SLOT = 2'd3;

	// One encoded group: four 6-bit symbol indexes, pad marks for slots 2 and 3,
	// and whether slot 3 ends the stream.
	typedef struct packed {
		logic [CHARS_PER_GROUP-1:0][5:0] idx;
		logic                             pad2;
		logic                             pad3;
		logic                             last;
	} group_t;

	// Map a 6-bit value onto the variant alphabet.
	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] v8;
		logic [7:0] c;
		v8 = {2'b00, v};
		if (v < 6'd26) begin
			c = 8'h41 + v8;
		end else if (v < 6'd52) begin
			c = 8'h61 + v8 - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + v8 - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2E;
		end else begin
			c = 8'h40;
		end
		return c;
	endfunction

endpackage

@@ rtl/base64_variant_encoder.sv @@
// Top level of the base64 variant encoder: front end, group queue, back end.
// Depends on b64v_pkg, b64v_front, b64v_queue, b64v_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------
//  input    | push / full        | data_byte, end_of_stream
//  result   | empty / pop        | out_char, last_char
//
// A byte is taken whenever the group queue has room; three bytes
// (or a final tail) form a group of four characters.
// The back end sends one character per cycle while each one is popped, so the
// sustained rate is set by the single character output.
// Reset clears the open-group count, queue pointers and the output valid flag.
// A stalled result side fills the two-entry queue, then full stops input.
`timescale 1ns / 1ps
module base64_variant_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       last_char
);
	import b64v_pkg::*;

	group_t q_wr_data;
	group_t q_rd_data;
	logic   q_wr;
	logic   q_rd;
	logic   q_full;
	logic   q_empty;

	assign full = q_full;

	b64v_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.q_full        (q_full),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_wr          (q_wr),
		.q_wr_data     (q_wr_data)
	);

	b64v_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	b64v_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd_data (q_rd_data),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

@@ rtl/b64v_front.sv @@
// Front end: accepts bytes, holds the open group and forms encoded groups.
// Depends on b64v_pkg.
`timescale 1ns / 1ps
module b64v_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              q_full,
	input  logic [7:0]        data_byte,
	input  logic              end_of_stream,
	output logic              q_wr,
	output b64v_pkg::group_t  q_wr_data
);
	import b64v_pkg::*;

	logic [7:0] pend_q [2];
	logic [1:0] count_q;
	logic       accept;
	logic       emit;
	logic [7:0] a0;
	logic [7:0] a1;
	logic [7:0] b;

	assign accept = push && !q_full;
	assign a0 = pend_q[0];
	assign a1 = pend_q[1];
	assign b  = data_byte;
	// Count three never occurs; treat it like two.
	assign emit = count_q[1] || end_of_stream;
	assign q_wr = accept && emit;

	always_comb begin
		q_wr_data = '0;
		if (count_q[1]) begin
			q_wr_data.idx[0] = a0[7:2];
			q_wr_data.idx[1] = {a0[1:0], a1[7:4]};
			q_wr_data.idx[2] = {a1[3:0], b[7:6]};
			q_wr_data.idx[3] = b[5:0];
			q_wr_data.last   = end_of_stream;
		end else if (count_q[0]) begin
			q_wr_data.idx[0] = a0[7:2];
			q_wr_data.idx[1] = {a0[1:0], b[7:4]};
			q_wr_data.idx[2] = {b[3:0], 2'b00};
			q_wr_data.pad3   = 1'b1;
			q_wr_data.last   = 1'b1;
		end else begin
			q_wr_data.idx[0] = b[7:2];
			q_wr_data.idx[1] = {b[1:0], 4'h0};
			q_wr_data.pad2   = 1'b1;
			q_wr_data.pad3   = 1'b1;
			q_wr_data.last   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			count_q <= emit ? 2'd0 : count_q + 2'd1;
		end
	end

	// Hold a byte of the open group.
	always_ff @(posedge clk) begin
		if (accept && !emit) begin
			pend_q[count_q[0]] <= data_byte;
		end
	end

endmodule

@@ rtl/b64v_queue.sv @@
// Two-entry group queue between front and back end.
// Depends on b64v_pkg.
`timescale 1ns / 1ps
module b64v_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  b64v_pkg::group_t  wr_data,
	input  logic              rd,
	output b64v_pkg::group_t  rd_data,
	output logic              full,
	output logic              empty
);
	import b64v_pkg::*;

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	group_t            slot_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CntW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/b64v_back.sv @@
// Back end: serializes queued groups into characters, one per cycle while pop keeps up.
// Depends on b64v_pkg and base64_variant_encoder_macros.svh.
`timescale 1ns / 1ps
`include "base64_variant_encoder_macros.svh"
module b64v_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64v_pkg::group_t  q_rd_data,
	input  logic              q_empty,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_char,
	output logic              last_char
);
	import b64v_pkg::*;

	logic [1:0] slot_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_char_q;
	logic       out_load;
	logic       taken;
	logic       is_pad;
	logic [7:0] next_char;

	assign taken    = pop && out_valid_q;
	assign out_load = !q_empty && (!out_valid_q || taken);
	assign q_rd     = out_load && (slot_q == LAST_SLOT);

	always_comb begin
		case (slot_q)
			2'd2:    is_pad = q_rd_data.pad2;
			2'd3:    is_pad = q_rd_data.pad3;
			default: is_pad = 1'b0;
		endcase
		next_char = is_pad ? PAD_CHAR : sym(q_rd_data.idx[slot_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				slot_q      <= slot_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q  <= next_char;
			last_char_q <= (slot_q == LAST_SLOT) && q_rd_data.last;
		end
	end

	assign empty     = !out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_char_q;

	`B64V_ASSERT_NEXT(a_wrap, out_load && slot_q == LAST_SLOT, slot_q == 2'd0, "slot did not wrap")
	`B64V_ASSERT_NEXT(a_last_pos, out_load && slot_q != LAST_SLOT, !last_char_q, "last mark off slot 3")
	`B64V_ASSERT_NEXT(a_no_early_pad, out_load && !slot_q[1], out_char_q != PAD_CHAR, "pad in slot 0 or 1")

endmodule
